// ===== rtl/core/gaussian_elimination_solver_core_assert.svh =====
// Assertion macros for the linear system solver core.
// Included by the controller and the top level; no other dependencies.
`ifndef GAUSSIAN_ELIMINATION_SOLVER_CORE_ASSERT_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GES_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GES_ASSERT(label, clk, rst_n, prop, msg)
`define GES_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/ges_pkg.sv =====
// Shared types and constants for the linear system solver core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ges_pkg;
  localparam int unsigned MaxDimDefault   = 8;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned DataW           = 32;
  localparam int unsigned SizeW           = 4;
  localparam int unsigned IdxOutW         = 3;
  localparam logic [0:0]  RegSizeInUse    = 1'b0;

  // datapath operation codes
  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,   // store load element
    OP_RDPIV,   // read pivot a[k][k] into pivot register
    OP_FACTOR,  // read a[i][k], start divide by pivot
    OP_UPDATE,  // a[i][j] -= f * a[k][j]
    OP_BACCUM,  // acc += a[i][j] * x[j]
    OP_BROOT,   // start divide (rhs - acc) / pivot, store x[i]
    OP_EMIT     // read x[i] for output
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] aux;     // k for update, i for emit
    logic [31:0] wdata;
  } cmd_t;

  typedef struct packed {
    logic busy;       // datapath op in flight or being issued
    logic piv_zero;   // pivot register holds zero
    logic [31:0] root;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/ges_div.sv =====
// Restoring divider: sat32((a << FRAC) / b), truncated toward zero.
// Depends on ges_pkg. One quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ges_div #(
  parameter int unsigned FracBits = ges_pkg::FracBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [31:0]      q_o
);
  localparam int unsigned NumW = 32 + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] num_q, num_d;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [32:0]     trial;
  logic [NumW:0]   qmag;
  logic [NumW+1:0] qs;
  logic [31:0]     amag, bmag;

  assign amag = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign bmag = b_i[31] ? (~b_i + 32'd1) : b_i;
  assign trial = {rem_q[31:0], num_q[NumW-1]} - {1'b0, den_q};

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d  = {amag, {FracBits{1'b0}}};
      rem_d  = '0;
      den_d  = bmag;
      neg_d  = a_i[31] ^ b_i[31];
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = {1'b0, trial[31:0]};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], num_q[NumW-1]};
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // num_q holds the quotient magnitude after the last step
  assign qmag = {1'b0, num_q};
  assign qs   = neg_q ? -{1'b0, qmag} : {1'b0, qmag};
  always_comb begin
    if (!neg_q && (qmag > (NumW+1)'(32'h7fffffff))) q_o = 32'h7fffffff;
    else if (neg_q && (qmag > (NumW+1)'(33'h80000000))) q_o = 32'h80000000;
    else q_o = qs[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end
  assign busy_o = busy_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

// ===== rtl/core/ges_datapath.sv =====
// Matrix memory, solution store, multiplier, accumulator and divider.
// Depends on ges_pkg and ges_div; driven by ges_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module ges_datapath #(
  parameter int unsigned MaxDim   = ges_pkg::MaxDimDefault,
  parameter int unsigned FracBits = ges_pkg::FracBitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ges_pkg::cmd_t cmd_i,
  output ges_pkg::stat_t     stat_o
);
  localparam int unsigned RowLen = MaxDim + 1;
  localparam int unsigned Depth  = MaxDim * RowLen;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned XW     = $clog2(MaxDim);

  logic [31:0] mem [Depth];
  logic [31:0] xs  [MaxDim];
  logic [31:0] rd_q, piv_q, fac_q, x_q, rhs_q;
  logic signed [63:0] acc_q;

  // sequence per op: read (P_RD, P_RD2), then mul and write (P_MUL, P_WR) or divide (P_DIV)
  typedef enum logic [2:0] {P_IDLE, P_RD, P_RD2, P_MUL, P_WR, P_DIV} ph_e;
  ph_e ph_q;
  ges_pkg::op_e op_q;
  logic [3:0] row_q, col_q, aux_q;
  logic [63:0] prod_q;
  logic [31:0] opb_q;
  logic div_start, div_busy, div_done;
  logic [31:0] div_a, div_q;
  logic started_q;

  function automatic logic [AW-1:0] addr(input logic [3:0] r, input logic [3:0] c);
    logic [AW+4:0] t;
    t = (AW+5)'(r) * (AW+5)'(RowLen) + (AW+5)'(c);
    return t[AW-1:0];
  endfunction

  function automatic logic [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sh7fffffff) return 32'h7fffffff;
    if (v < -66'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  // floor shift of product: arithmetic shift right, which floors for both signs
  logic signed [63:0] pshift;
  assign pshift = $signed(prod_q) >>> FracBits;

  logic [AW-1:0] ra;
  always_comb begin
    unique case (ph_q)
      P_RD2: ra = addr(aux_q, col_q);
      default: ra = addr(row_q, col_q);
    endcase
  end

  logic [31:0] rhs_sat;
  assign rhs_sat = sat(66'(signed'(rd_q)) - 66'(acc_q));
  assign div_a   = (op_q == ges_pkg::OP_BROOT) ? rhs_sat : rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ges_pkg::OP_WRITE) mem[addr(cmd_i.row, cmd_i.col)] <= cmd_i.wdata;
    else if (ph_q == P_WR && op_q == ges_pkg::OP_UPDATE)
      mem[addr(row_q, col_q)] <= sat(66'(signed'(rd_q)) - 66'(pshift));
    // rd_q keeps a[row][col] while the second operand is read
    if (ph_q != P_RD2) rd_q <= mem[ra];
    if (ph_q == P_RD2) opb_q <= mem[ra];
    if (ph_q == P_MUL) prod_q <= (op_q == ges_pkg::OP_UPDATE) ?
        64'($signed(fac_q) * $signed(opb_q)) : 64'($signed(rd_q) * $signed(x_q));
    if (div_done && op_q == ges_pkg::OP_BROOT)
      xs[row_q[XW-1:0]] <= (piv_q == '0) ? '0 : div_q;
    if (div_done && op_q == ges_pkg::OP_FACTOR) fac_q <= div_q;
    if (ph_q == P_RD && op_q == ges_pkg::OP_RDPIV) piv_q <= mem[ra];
    x_q <= xs[col_q[XW-1:0]];
    rhs_q <= xs[aux_q[XW-1:0]];
  end

  assign div_start = (ph_q == P_DIV) && !div_busy && !div_done && !started_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= P_IDLE; op_q <= ges_pkg::OP_NONE; acc_q <= '0; started_q <= 1'b0;
      row_q <= '0; col_q <= '0; aux_q <= '0;
    end else begin
      unique case (ph_q)
        P_IDLE: begin
          if (cmd_i.op != ges_pkg::OP_NONE && cmd_i.op != ges_pkg::OP_WRITE) begin
            op_q <= cmd_i.op; row_q <= cmd_i.row; col_q <= cmd_i.col;
            aux_q <= cmd_i.aux;
            if (cmd_i.op == ges_pkg::OP_RDPIV) acc_q <= '0;
            ph_q <= P_RD;
          end
        end
        P_RD: begin
          // rd_q now valid next cycle
          ph_q <= P_RD2;
        end
        P_RD2: begin
          priority case (op_q)
            ges_pkg::OP_RDPIV, ges_pkg::OP_EMIT: ph_q <= P_IDLE;
            ges_pkg::OP_FACTOR, ges_pkg::OP_BROOT: begin
              ph_q <= P_DIV; started_q <= 1'b0;
            end
            default: ph_q <= P_MUL;
          endcase
        end
        P_MUL: ph_q <= P_WR;
        P_WR: begin
          if (op_q == ges_pkg::OP_BACCUM) acc_q <= acc_q + pshift;
          ph_q <= P_IDLE;
        end
        P_DIV: begin
          if (div_start) started_q <= 1'b1;
          if (div_done && started_q) begin
            ph_q <= P_IDLE;
            if (op_q == ges_pkg::OP_BROOT) acc_q <= '0;
          end
        end
        default: ph_q <= P_IDLE;
      endcase
    end
  end

  ges_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(div_a), .b_i(piv_q),
    .busy_o(div_busy), .done_o(div_done), .q_o(div_q)
  );

  assign stat_o.busy     = (ph_q != P_IDLE) || (cmd_i.op != ges_pkg::OP_NONE &&
                           cmd_i.op != ges_pkg::OP_WRITE);
  assign stat_o.piv_zero = (piv_q == '0);
  assign stat_o.root     = rhs_q;
endmodule
`default_nettype wire

// ===== rtl/core/ges_ctrl.sv =====
// Sequencer: load counting, elimination and back-substitution loops, emit.
// Depends on ges_pkg; issues commands to ges_datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_elimination_solver_core_assert.svh"
module ges_ctrl #(
  parameter int unsigned MaxDim = ges_pkg::MaxDimDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [3:0]     cfg_size_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [31:0]    in_data_i,
  output ges_pkg::cmd_t       cmd_o,
  input  wire ges_pkg::stat_t stat_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [31:0]         out_root_o,
  output logic [2:0]          out_idx_o,
  output logic                out_last_o,
  output logic                out_sing_o
);
  localparam logic [3:0] S_LOAD = 4'd0, S_PIV = 4'd1, S_PIVW = 4'd2, S_FAC = 4'd3,
    S_FACW = 4'd4, S_UPD = 4'd5, S_UPDW = 4'd6, S_BPIV = 4'd7, S_BPIVW = 4'd8,
    S_BACC = 4'd9, S_BACCW = 4'd10, S_BRT = 4'd11, S_BRTW = 4'd12, S_EM = 4'd13,
    S_EMW = 4'd14, S_OUT = 4'd15;

  logic [3:0] st_q, st_d, n_q, n_d, r_q, r_d, c_q, c_d, k_q, k_d, i_q, i_d;
  logic sing_q, sing_d, issued_q, issued_d;
  logic [3:0] n_eff, cfg_n;
  logic [31:0] root_q, root_d;

  always_comb begin
    cfg_n = cfg_size_i;
    if (cfg_n == 4'd0) cfg_n = 4'd1;
    if (32'(cfg_n) > MaxDim) cfg_n = 4'(MaxDim);
  end
  assign n_eff = n_q;

  assign in_ready_o = (st_q == S_LOAD);

  always_comb begin
    st_d = st_q; n_d = n_q; r_d = r_q; c_d = c_q; k_d = k_q; i_d = i_q;
    sing_d = sing_q; issued_d = 1'b0; root_d = root_q;
    cmd_o = '0; cmd_o.op = ges_pkg::OP_NONE;
    if (cfg_we_i) begin
      n_d = cfg_n; r_d = '0; c_d = '0; sing_d = 1'b0; st_d = S_LOAD;
    end else begin
      unique case (st_q)
        S_LOAD: if (in_valid_i) begin
          cmd_o.op = ges_pkg::OP_WRITE; cmd_o.row = r_q; cmd_o.col = c_q;
          cmd_o.wdata = in_data_i;
          if (r_q == '0 && c_q == '0) sing_d = 1'b0;
          if (c_q == n_eff) begin
            c_d = '0;
            if (r_q == n_eff - 4'd1) begin
              r_d = '0; k_d = '0; st_d = S_PIV;
            end else r_d = r_q + 4'd1;
          end else c_d = c_q + 4'd1;
        end
        S_PIV: begin
          cmd_o.op = ges_pkg::OP_RDPIV; cmd_o.row = k_q; cmd_o.col = k_q;
          st_d = S_PIVW; issued_d = 1'b1;
        end
        S_PIVW: if (!issued_q && !stat_i.busy) begin
          if (stat_i.piv_zero || k_q + 4'd1 >= n_eff) begin
            if (stat_i.piv_zero) sing_d = 1'b1;
            if (k_q + 4'd1 >= n_eff) begin
              i_d = n_eff - 4'd1; st_d = S_BPIV;
            end else begin
              k_d = k_q + 4'd1; st_d = S_PIV;
            end
          end else begin
            i_d = k_q + 4'd1; st_d = S_FAC;
          end
        end
        S_FAC: begin
          cmd_o.op = ges_pkg::OP_FACTOR; cmd_o.row = i_q; cmd_o.col = k_q;
          st_d = S_FACW; issued_d = 1'b1; c_d = k_q;
        end
        S_FACW: if (!issued_q && !stat_i.busy) st_d = S_UPD;
        S_UPD: begin
          cmd_o.op = ges_pkg::OP_UPDATE; cmd_o.row = i_q; cmd_o.col = c_q;
          cmd_o.aux = k_q; st_d = S_UPDW; issued_d = 1'b1;
        end
        S_UPDW: if (!issued_q && !stat_i.busy) begin
          if (c_q == n_eff) begin
            if (i_q + 4'd1 >= n_eff) begin
              k_d = k_q + 4'd1; st_d = S_PIV;
            end else begin
              i_d = i_q + 4'd1; st_d = S_FAC;
            end
          end else begin
            c_d = c_q + 4'd1; st_d = S_UPD;
          end
        end
        S_BPIV: begin
          cmd_o.op = ges_pkg::OP_RDPIV; cmd_o.row = i_q; cmd_o.col = i_q;
          st_d = S_BPIVW; issued_d = 1'b1; c_d = i_q + 4'd1;
        end
        S_BPIVW: if (!issued_q && !stat_i.busy) begin
          if (stat_i.piv_zero) sing_d = 1'b1;
          st_d = (c_q < n_eff) ? S_BACC : S_BRT;
        end
        S_BACC: begin
          cmd_o.op = ges_pkg::OP_BACCUM; cmd_o.row = i_q; cmd_o.col = c_q;
          st_d = S_BACCW; issued_d = 1'b1;
        end
        S_BACCW: if (!issued_q && !stat_i.busy) begin
          c_d = c_q + 4'd1;
          st_d = (c_q + 4'd1 < n_eff) ? S_BACC : S_BRT;
        end
        S_BRT: begin
          cmd_o.op = ges_pkg::OP_BROOT; cmd_o.row = i_q; cmd_o.col = n_eff;
          st_d = S_BRTW; issued_d = 1'b1;
        end
        S_BRTW: if (!issued_q && !stat_i.busy) begin
          if (i_q == '0) st_d = S_EM;
          else begin
            i_d = i_q - 4'd1; st_d = S_BPIV;
          end
        end
        S_EM: begin
          cmd_o.op = ges_pkg::OP_EMIT; cmd_o.aux = i_q;
          st_d = S_EMW; issued_d = 1'b1;
        end
        S_EMW: if (!issued_q && !stat_i.busy) begin
          root_d = stat_i.root; st_d = S_OUT;
        end
        S_OUT: if (out_ready_i) begin
          if (i_q == n_eff - 4'd1) begin
            st_d = S_LOAD; r_d = '0; c_d = '0;
          end else begin
            i_d = i_q + 4'd1; st_d = S_EM;
          end
        end
        default: st_d = S_LOAD;
      endcase
    end
  end

  assign out_valid_o = (st_q == S_OUT);
  assign out_root_o  = root_q;
  assign out_idx_o   = i_q[2:0];
  assign out_last_o  = (i_q == n_eff - 4'd1);
  assign out_sing_o  = sing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; n_q <= 4'(MaxDim > 8 ? 8 : MaxDim); r_q <= '0; c_q <= '0;
      k_q <= '0; i_q <= '0; sing_q <= 1'b0; issued_q <= 1'b0;
    end else begin
      st_q <= st_d; n_q <= n_d; r_q <= r_d; c_q <= c_d; k_q <= k_d; i_q <= i_d;
      sing_q <= sing_d; issued_q <= issued_d;
    end
  end
  always_ff @(posedge clk_i) root_q <= root_d;

  `GES_ASSERT(a_ready_load, clk_i, rst_ni, in_ready_o |-> !out_valid_o, "ready while emitting")
  `GES_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i && !cfg_we_i) |=> $stable(out_root_o), "root changed under stall")
  `GES_ASSERT(a_n_range, clk_i, rst_ni, (n_q != 4'd0), "size is zero")
endmodule
`default_nettype wire

// ===== rtl/core/gaussian_elimination_solver_core.sv =====
// Linear system solver core (Gaussian elimination, back substitution).
// Slave stream s_axis_* takes matrix elements (signed Q16.16), row-major,
// n*(n+1) beats per system. After the last beat the core eliminates without
// pivoting and back-substitutes, then sends n root beats on m_axis_*,
// index order, tlast on root n-1. A zero pivot sets the singular bit and
// zeroes that row's root. Loading accepts one beat per cycle; the solve
// runs on one product register and one bit-serial divider (48 quotient
// steps per divide), about n^3/3 multiply-subtract steps plus n^2/2
// divides; each step finishes before the next one is issued.
// Each root beat is read from the solution store before it is offered.
// s_axis_tready is low from the last load beat until the last root beat
// is taken. A stalled receiver holds the root beat unchanged.
// Reset (rst_ni low) sets size to 8 and restarts the load; writing the
// size register over APB at address 0 also restarts the load.
// Depends on ges_pkg, ges_ctrl, ges_datapath, ges_div.
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_elimination_solver_core_assert.svh"
module gaussian_elimination_solver_core #(
  parameter int unsigned MaxDim   = ges_pkg::MaxDimDefault,
  parameter int unsigned FracBits = ges_pkg::FracBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] matrix_element
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] root_value, [34:32] root_index
  output logic             m_axis_tlast,
  output logic             m_axis_tuser    // singular
);
  localparam logic [1:0] SizeAddr = 2'(4 * ges_pkg::RegSizeInUse);

  ges_pkg::cmd_t  cmd;
  ges_pkg::stat_t stat;
  logic cfg_we;
  logic [3:0] size_q;
  logic [31:0] root;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == SizeAddr);
  assign prdata = (paddr == SizeAddr) ? {28'd0, size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= 4'd8;
    else if (cfg_we) size_q <= pwdata[3:0];
  end

  ges_ctrl #(.MaxDim(MaxDim)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_size_i(pwdata[3:0]),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .cmd_o(cmd), .stat_i(stat),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_root_o(root), .out_idx_o(idx), .out_last_o(m_axis_tlast),
    .out_sing_o(m_axis_tuser)
  );

  ges_datapath #(.MaxDim(MaxDim), .FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat)
  );

  assign m_axis_tdata = {5'd0, idx, root};

  `GES_ASSERT(a_no_both, clk_i, rst_ni, !(s_axis_tready && m_axis_tvalid), "in and out at once")
  `GES_ASSERT(a_valid_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready && !cfg_we) |=> m_axis_tvalid, "valid dropped under stall")
  `GES_ASSERT(a_ready_pready, clk_i, rst_ni, pready, "pready low")
endmodule
`default_nettype wire
